[design/cdq_pkg.sv]
package cdq_pkg;

    // ring size
    localparam int CDQ_DEPTH = 16;

    // word width of one entry
    localparam int CDQ_WORD_W = 32;

    typedef logic signed [CDQ_WORD_W-1:0] t_word;

    // operation codes of an input item
    typedef enum logic [2:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_REAR  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_REAR   = 3'd3,
        KIND_PEEK_FRONT = 3'd4
    } t_kind;

    // per-cycle command broadcast along the cell row
    typedef enum logic [2:0] {
        CELL_HOLD       = 3'd0,
        CELL_SHIFT_R    = 3'd1,
        CELL_WRITE_REAR = 3'd2,
        CELL_SHIFT_L    = 3'd3,
        CELL_DROP_REAR  = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_word    value;
    } t_cell_cmd;

endpackage

[design/cdq_if.sv]
interface cdq_in_if import cdq_pkg::*;;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    t_word       value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface cdq_out_if import cdq_pkg::*;;
    logic        valid;
    logic        ready;
    t_word       data;
    logic        ok;
    logic        empty_res;
    logic        full_res;

    modport source (output valid, output data, output ok, output empty_res,
                    output full_res, input ready);
    modport sink   (input valid, input data, input ok, input empty_res,
                    input full_res, output ready);
endinterface

[design/circular_deque_top.sv]
// result: registered in the output register when the item is accepted
// throughput: one item per cycle while results are taken; the whole cell row
//   updates together and the rear word is picked by an and-or select over all cells
// reset: synchronous, active low; clears cell occupancy and the output valid,
//   stored words are not cleared
module circular_deque_top import cdq_pkg::*; #(
    parameter int DEPTH = CDQ_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cdq_in_if.sink           i_in,
    cdq_out_if.source        o_out
);

    t_word             w_data [DEPTH];
    logic [DEPTH-1:0]  w_occ;
    logic [DEPTH-1:0]  w_last;
    t_word             w_rear;
    t_cell_cmd         w_cmd;
    logic              w_accept;
    logic              w_empty;
    logic              w_full;
    logic              w_ok;
    t_word             w_res_data;
    logic              w_res_empty;
    logic              w_res_full;

    logic              r_out_valid;
    t_word             r_out_data;
    logic              r_out_ok;
    logic              r_out_empty;
    logic              r_out_full;

    // handshake: the output register frees as its item is taken
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    // flags from the occupancy thermometer
    assign w_empty = !w_occ[0];
    assign w_full  = w_occ[DEPTH-1];
    assign w_last  = w_occ & ~{1'b0, w_occ[DEPTH-1:1]};

    // rear word: one-hot select of the last occupied cell
    always_comb begin
        w_rear = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (w_last[k]) begin
                w_rear = w_rear | w_data[k];
            end
        end
    end

    // decode the item into a row command and its result
    always_comb begin
        w_ok        = 1'b0;
        w_res_data  = '1;
        w_res_empty = w_empty;
        w_res_full  = w_full;
        w_cmd.op    = CELL_HOLD;
        w_cmd.value = i_in.value;
        case (i_in.kind)
            KIND_PUSH_FRONT: begin
                if (!w_full) begin
                    w_ok        = 1'b1;
                    w_cmd.op    = CELL_SHIFT_R;
                    w_res_empty = 1'b0;
                    w_res_full  = w_occ[DEPTH-2];
                end
            end
            KIND_PUSH_REAR: begin
                if (!w_full) begin
                    w_ok        = 1'b1;
                    w_cmd.op    = CELL_WRITE_REAR;
                    w_res_empty = 1'b0;
                    w_res_full  = w_occ[DEPTH-2];
                end
            end
            KIND_POP_FRONT: begin
                if (!w_empty) begin
                    w_ok        = 1'b1;
                    w_cmd.op    = CELL_SHIFT_L;
                    w_res_data  = w_data[0];
                    w_res_empty = !w_occ[1];
                    w_res_full  = 1'b0;
                end
            end
            KIND_POP_REAR: begin
                if (!w_empty) begin
                    w_ok        = 1'b1;
                    w_cmd.op    = CELL_DROP_REAR;
                    w_res_data  = w_rear;
                    w_res_empty = !w_occ[1];
                    w_res_full  = 1'b0;
                end
            end
            KIND_PEEK_FRONT: begin
                if (!w_empty) begin
                    w_ok       = 1'b1;
                    w_res_data = w_data[0];
                end
            end
            default: begin
            end
        endcase
        if (!w_accept) begin
            w_cmd.op = CELL_HOLD;
        end
    end

    // row of cells, front at cell 0
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_word w_left_data;
        logic  w_left_occ;
        t_word w_right_data;
        logic  w_right_occ;

        if (k == 0) begin : g_first
            assign w_left_data = i_in.value;
            assign w_left_occ  = 1'b1;
        end else begin : g_inner_left
            assign w_left_data = w_data[k-1];
            assign w_left_occ  = w_occ[k-1];
        end

        if (k == DEPTH - 1) begin : g_end
            assign w_right_data = '0;
            assign w_right_occ  = 1'b0;
        end else begin : g_inner_right
            assign w_right_data = w_data[k+1];
            assign w_right_occ  = w_occ[k+1];
        end

        cdq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_left_data  (w_left_data),
            .i_left_occ   (w_left_occ),
            .i_right_data (w_right_data),
            .i_right_occ  (w_right_occ),
            .o_data       (w_data[k]),
            .o_occ        (w_occ[k])
        );
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data  <= w_res_data;
            r_out_ok    <= w_ok;
            r_out_empty <= w_res_empty;
            r_out_full  <= w_res_full;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.data      = r_out_data;
    assign o_out.ok        = r_out_ok;
    assign o_out.empty_res = r_out_empty;
    assign o_out.full_res  = r_out_full;

    // occupied cells always form a run from cell 0
    a_occ_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot({1'b0, w_occ} + {{DEPTH{1'b0}}, 1'b1}))
        else $error("occupancy is not a contiguous run from the front");

    // occupancy moves only on an accepted item
    a_occ_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(w_occ))
        else $error("occupancy changed without an item");

    // a push into a full ring fails
    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_full &&
        (i_in.kind == KIND_PUSH_FRONT || i_in.kind == KIND_PUSH_REAR)
        |=> !o_out.ok && o_out.full_res)
        else $error("push into a full ring reported success");

    // a pop from the front returns the front word
    a_pop_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !w_empty && i_in.kind == KIND_POP_FRONT
        |=> o_out.ok && o_out.data == $past(w_data[0]))
        else $error("front pop returned the wrong word");

endmodule

[design/cdq_cell.sv]
module cdq_cell import cdq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_word     i_left_data,
    input  logic      i_left_occ,
    input  t_word     i_right_data,
    input  logic      i_right_occ,
    output t_word     o_data,
    output logic      o_occ
);

    t_word r_data;
    t_word n_data;
    logic  r_occ;
    logic  n_occ;

    // next word and occupancy from the row command and the neighbours
    always_comb begin
        n_data = r_data;
        n_occ  = r_occ;
        case (i_cmd.op)
            CELL_SHIFT_R: begin
                n_data = i_left_data;
                n_occ  = i_left_occ;
            end
            CELL_WRITE_REAR: begin
                // first free cell takes the word
                if (!r_occ && i_left_occ) begin
                    n_data = i_cmd.value;
                    n_occ  = 1'b1;
                end
            end
            CELL_SHIFT_L: begin
                n_data = i_right_data;
                n_occ  = i_right_occ;
            end
            CELL_DROP_REAR: begin
                // last occupied cell lets go, its word stays
                n_occ = r_occ && i_right_occ;
            end
            CELL_HOLD: begin
            end
            default: begin
            end
        endcase
    end

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    // stored word
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_occ  = r_occ;

endmodule
